// ----- design/lpfd_pkg.sv -----
// Package for the length-prefixed frame deframer.
// Holds the item and result types, the opcode, status and header-phase codes.
// No dependencies.
package lpfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned FramesW  = 32;
  localparam logic [LenW-1:0] MaxLenReset = 16'd256;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } lpfd_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_FAILED    = 3'd3,
    ST_TRUNCATED = 3'd4
  } lpfd_status_e;

  // Header phase: waiting for the high length byte, the low one, or in payload.
  typedef enum logic [1:0] {
    HDR_HIGH = 2'd0,
    HDR_LOW  = 2'd1,
    HDR_DONE = 2'd2
  } lpfd_hdr_e;

  typedef struct packed {
    lpfd_op_e         opcode;
    logic [ByteW-1:0] data_byte;
    logic             sink_accept;
  } lpfd_item_t;

  typedef struct packed {
    lpfd_status_e       status;
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic               frame_last;
    logic [LenW-1:0]    frame_length;
    logic [FramesW-1:0] frames_accepted;
  } lpfd_result_t;

endpackage

// ----- design/length_prefixed_frame_deframer.sv -----
// Length-prefixed frame deframer, top level.
// Path: an accepted input item waits in the input register until the result register has room,
// then its parse result is loaded into the result register and offered on the result channel.
// Throughput: one item per cycle; the input and result registers each hold one item and the
// parse logic steps one item per cycle, so transfers continue back to back while the sink is
// ready. Reset (rst_ni, async, active low): parse state, counter and valids clear; max 256.
module length_prefixed_frame_deframer import lpfd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: maximum payload length
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            opcode_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic            sink_accept_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic            payload_valid_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic            frame_last_o,
  output logic [LenW-1:0] frame_length_o,
  output logic [FramesW-1:0] frames_accepted_o
);

  lpfd_item_t   in_item;
  lpfd_item_t   stage_item;
  logic         stage_valid;
  logic         out_free;
  logic         advance;
  lpfd_result_t core_res;
  lpfd_result_t out_res;

  // Pack the incoming fields into one item.
  assign in_item.opcode      = lpfd_op_e'(opcode_i);
  assign in_item.data_byte   = data_byte_i;
  assign in_item.sink_accept = sink_accept_i;

  // Advance the held item through the parser whenever the result register
  // has room; parse state commits on the same edge.
  assign advance = stage_valid && out_free;

  lpfd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  lpfd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (stage_item),
    .result_o    (core_res)
  );

  lpfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  // Unpack the held result onto the field ports.
  assign status_o          = out_res.status;
  assign payload_valid_o   = out_res.payload_valid;
  assign payload_byte_o    = out_res.payload_byte;
  assign frame_last_o      = out_res.frame_last;
  assign frame_length_o    = out_res.frame_length;
  assign frames_accepted_o = out_res.frames_accepted;

endmodule

// ----- design/lpfd_in_stage.sv -----
// Input register of the deframer: holds one accepted item until the core takes it.
// Depends on lpfd_pkg.
module lpfd_in_stage import lpfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lpfd_item_t item_i,
  input  logic       take_i,
  output logic       valid_o,
  output lpfd_item_t item_o
);

  logic       valid_q, valid_d;
  lpfd_item_t item_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/lpfd_core.sv -----
// Frame parsing state and the single-step update for one item.
// Depends on lpfd_pkg.
module lpfd_core import lpfd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            step_i,
  input  lpfd_item_t      item_i,
  output lpfd_result_t    result_o
);

  lpfd_hdr_e              hdr_q, hdr_d;
  logic [ByteW-1:0]       hi_q, hi_d;
  logic [LenW-1:0]        exp_q, exp_d;
  logic [LenW-1:0]        pbs_q, pbs_d;
  logic                   failed_q, failed_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [LenW-1:0]        max_q;
  logic [LenW-1:0]        new_len;
  logic [LenW-1:0]        pbs_inc;
  logic [FramesW-1:0]     cnt_out;

  assign new_len = {hi_q, item_i.data_byte};
  assign pbs_inc = pbs_q + LenW'(1);

  generate
    if (COUNT_WIDTH >= FramesW) begin : g_cnt_trunc
      assign cnt_out = cnt_d[FramesW-1:0];
    end else begin : g_cnt_ext
      assign cnt_out = {{(FramesW-COUNT_WIDTH){1'b0}}, cnt_d};
    end
  endgenerate

  always_comb begin
    hdr_d    = hdr_q;
    hi_d     = hi_q;
    exp_d    = exp_q;
    pbs_d    = pbs_q;
    failed_d = failed_q;
    cnt_d    = cnt_q;
    result_o.status        = ST_OK;
    result_o.payload_valid = 1'b0;
    result_o.payload_byte  = '0;
    result_o.frame_last    = 1'b0;
    result_o.frame_length  = exp_q;

    if (item_i.opcode == OP_FINISH) begin
      if (failed_q) begin
        result_o.status = ST_FAILED;
      end else if (hdr_q != HDR_HIGH || pbs_q != '0 || exp_q != '0) begin
        result_o.status = ST_TRUNCATED;
      end
    end else if (failed_q) begin
      result_o.status = ST_FAILED;
    end else begin
      unique case (hdr_q)
        HDR_HIGH: begin
          hi_d  = item_i.data_byte;
          hdr_d = HDR_LOW;
        end
        HDR_LOW: begin
          exp_d = new_len;
          hdr_d = HDR_DONE;
          result_o.frame_length = new_len;
          if (new_len == '0 || new_len > max_q) begin
            failed_d        = 1'b1;
            result_o.status = ST_BAD_LEN;
          end
        end
        HDR_DONE: begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = item_i.data_byte;
          pbs_d = pbs_inc;
          if (pbs_inc == exp_q) begin
            result_o.frame_last = 1'b1;
            if (item_i.sink_accept) begin
              cnt_d = cnt_q + COUNT_WIDTH'(1);
              hdr_d = HDR_HIGH;
              pbs_d = '0;
              exp_d = '0;
            end else begin
              failed_d        = 1'b1;
              result_o.status = ST_REJECTED;
            end
          end
        end
        default: begin
          hdr_d = HDR_HIGH;
        end
      endcase
    end
    result_o.frames_accepted = cnt_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HDR_HIGH;
      hi_q     <= '0;
      exp_q    <= '0;
      pbs_q    <= '0;
      failed_q <= 1'b0;
      cnt_q    <= '0;
    end else if (step_i) begin
      hdr_q    <= hdr_d;
      hi_q     <= hi_d;
      exp_q    <= exp_d;
      pbs_q    <= pbs_d;
      failed_q <= failed_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- design/lpfd_out_stage.sv -----
// Result register of the deframer: holds one result until the sink takes it.
// Depends on lpfd_pkg.
module lpfd_out_stage import lpfd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  lpfd_result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lpfd_result_t result_o
);

  logic         valid_q, valid_d;
  lpfd_result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule
